@@ rtl/core/serial_message_deframer_assert.svh @@
// Assertion macros for the deframer modules, used by the result queue.
`ifndef SERIAL_MESSAGE_DEFRAMER_ASSERT_SVH
`define SERIAL_MESSAGE_DEFRAMER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SMD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define SMD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/smd_pkg.sv @@
// Types and constants of the serial message deframer.
package smd_pkg;

  localparam int BUFFER_DEPTH_DEF = 64;
  localparam int CHAR_W           = 7;
  localparam int INDEX_W          = 6;
  localparam int LENGTH_W         = 7;
  localparam int REG_INDEX_W      = 2;
  localparam int QUEUE_DEPTH      = 4;

  localparam logic [REG_INDEX_W-1:0] REG_START_FIRST  = 2'd0;
  localparam logic [REG_INDEX_W-1:0] REG_START_SECOND = 2'd1;
  localparam logic [REG_INDEX_W-1:0] REG_END_MARKER   = 2'd2;

  localparam logic [CHAR_W-1:0] START_FIRST_RST  = 7'd36;
  localparam logic [CHAR_W-1:0] START_SECOND_RST = 7'd72;
  localparam logic [CHAR_W-1:0] END_MARKER_RST   = 7'd10;

  typedef struct packed {
    logic [CHAR_W-1:0] rx_byte;
    logic              rx_error;
    logic              tx_mode;
    logic              tx_idle;
  } char_t;

  typedef struct packed {
    logic                byte_valid;
    logic [INDEX_W-1:0]  byte_index;
    logic [CHAR_W-1:0]   byte_value;
    logic                last;
    logic                msg_start;
    logic                msg_done;
    logic [LENGTH_W-1:0] msg_length;
    logic                frame_abort;
    logic                error_seen;
    logic                activity_active;
    logic                tx_finished;
  } result_t;

  typedef struct packed {
    logic                   en;
    logic [REG_INDEX_W-1:0] index;
    logic [CHAR_W-1:0]      data;
  } cfg_wr_t;

endpackage

@@ rtl/core/smd_core.sv @@
// Deframer state, configuration registers and per-character step logic.
module smd_core #(
  parameter int BUFFER_DEPTH = smd_pkg::BUFFER_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  smd_pkg::cfg_wr_t cfg,
  input  logic            fire,
  input  smd_pkg::char_t  item,
  output smd_pkg::result_t res0,
  output smd_pkg::result_t res1,
  output logic            two
);
  import smd_pkg::*;

  localparam int WP_W = $clog2(BUFFER_DEPTH + 1);

  logic [CHAR_W-1:0] start_first, start_second, end_marker;

  logic              in_message, in_message_next;
  logic [CHAR_W-1:0] previous_char, previous_char_next;
  logic [WP_W-1:0]   write_pointer, write_pointer_next;
  logic              activity_slot, activity_slot_next;
  logic              sticky_error, sticky_error_next;
  logic              abort_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_first  <= START_FIRST_RST;
      start_second <= START_SECOND_RST;
      end_marker   <= END_MARKER_RST;
    end else if (cfg.en) begin
      unique case (cfg.index)
        REG_START_FIRST:  start_first  <= cfg.data;
        REG_START_SECOND: start_second <= cfg.data;
        REG_END_MARKER:   end_marker   <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_message    <= 1'b0;
      previous_char <= '0;
      write_pointer <= '0;
      activity_slot <= 1'b1;
      sticky_error  <= 1'b0;
    end else if (fire) begin
      in_message    <= in_message_next;
      previous_char <= previous_char_next;
      write_pointer <= write_pointer_next;
      activity_slot <= activity_slot_next;
      sticky_error  <= sticky_error_next;
    end
  end

  always_comb begin
    in_message_next    = in_message;
    previous_char_next = previous_char;
    write_pointer_next = write_pointer;
    activity_slot_next = activity_slot;
    sticky_error_next  = sticky_error;
    abort_now          = 1'b0;
    two                = 1'b0;
    res0               = '0;
    res0.last          = 1'b1;

    if (item.tx_mode) begin
      // echo of own transmission: only the final one matters
      if (item.tx_idle) begin
        activity_slot_next = 1'b0;
        in_message_next    = 1'b0;
        res0.tx_finished   = 1'b1;
      end
    end else if (item.rx_error) begin
      abort_now = 1'b1;
    end else if (in_message) begin
      previous_char_next = item.rx_byte;
      if (item.rx_byte == end_marker) begin
        in_message_next = 1'b0;
        res0.msg_done   = 1'b1;
        res0.msg_length = LENGTH_W'(write_pointer);
      end else if (write_pointer < WP_W'(BUFFER_DEPTH)) begin
        res0.byte_valid    = 1'b1;
        res0.byte_index    = INDEX_W'(write_pointer);
        res0.byte_value    = item.rx_byte;
        write_pointer_next = write_pointer + WP_W'(1);
      end else begin
        abort_now = 1'b1;
      end
    end else if (previous_char == start_first && item.rx_byte == start_second) begin
      in_message_next    = 1'b1;
      write_pointer_next = WP_W'(2);
      previous_char_next = item.rx_byte;
      two                = 1'b1;
      res0.byte_valid    = 1'b1;
      res0.byte_index    = '0;
      res0.byte_value    = start_first;
      res0.last          = 1'b0;
      res0.msg_start     = 1'b1;
    end else begin
      previous_char_next = item.rx_byte;
    end

    // abort: drop the frame and the start history, set the sticky error and activity slot
    if (abort_now) begin
      sticky_error_next  = 1'b1;
      previous_char_next = '0;
      activity_slot_next = 1'b1;
      write_pointer_next = '0;
      in_message_next    = 1'b0;
      res0.frame_abort   = 1'b1;
    end

    res0.error_seen      = sticky_error_next;
    res0.activity_active = activity_slot_next;

    res1            = res0;
    res1.byte_index = INDEX_W'(1);
    res1.byte_value = start_second;
    res1.last       = 1'b1;
  end

endmodule

@@ rtl/core/smd_out_queue.sv @@
// Small result queue taking up to two words a cycle and releasing one while res_stall is low.
module smd_out_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic [1:0]       push_n,
  input  smd_pkg::result_t wdata0,
  input  smd_pkg::result_t wdata1,
  output logic             room2,
  output logic             res_valid,
  input  logic             res_stall,
  output smd_pkg::result_t res
);
  import smd_pkg::*;

  `include "serial_message_deframer_assert.svh"

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  result_t          mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] head, tail;
  logic [CNT_W-1:0] count, count_next;
  logic             pop;

  assign res_valid  = (count != '0);
  assign res        = mem[head];
  assign pop        = res_valid && !res_stall;
  assign room2      = (count <= CNT_W'(QUEUE_DEPTH - 2));
  assign count_next = count + CNT_W'(push_n) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head + PTR_W'(pop);
      tail  <= tail + PTR_W'(push_n);
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[tail] <= wdata0;
    end
    if (push_n == 2'd2) begin
      mem[tail + PTR_W'(1)] <= wdata1;
    end
  end

  `SMD_ASSERT_NOW(a_pair_fits, push_n == 2'd2, count <= CNT_W'(QUEUE_DEPTH - 2), "pair pushed without room")
  `SMD_ASSERT_NOW(a_no_single_overflow, push_n == 2'd1, count < CNT_W'(QUEUE_DEPTH), "word pushed into full queue")
  `SMD_ASSERT_NEXT(a_drain, pop && push_n == 2'd0, count == $past(count) - CNT_W'(1), "pop did not drain a word")

endmodule

@@ rtl/core/serial_message_deframer.sv @@
// Serial message deframer: finds start pair, numbers message characters, flags errors.
//
// Use: each received character enters on the char channel (char_valid/char_stall)
// with its line error flag and the two flags of the local transmitter. Result
// words leave on the res channel (res_valid/res_stall); res.last marks the final
// word of a character. A detected start pair gives two words (buffer indexes 0
// and 1), every other character gives one.
// Path: a taken character is held in the input register, processed from there
// by the core, written into the result queue and offered from the queue.
// Throughput: one character per cycle while the queue has room for two words;
// start pair words leave by the single read port of the four-word result queue.
// The input register advances only while the queue has room for two words, so a
// stalled receiver fills the queue and then raises char_stall; nothing is lost.
// Reset (rst, synchronous) empties both stages, closes any message, clears the
// start history and sticky error, sets the activity slot and restores the start
// pair and end marker registers. Registers are written through wr_en, wr_index
// and wr_data by the user, only while the block is idle; the block does not check it.
module serial_message_deframer #(
  parameter int BUFFER_DEPTH = smd_pkg::BUFFER_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [smd_pkg::REG_INDEX_W-1:0]     wr_index,
  input  logic [smd_pkg::CHAR_W-1:0]          wr_data,
  input  logic                                char_valid,
  output logic                                char_stall,
  input  smd_pkg::char_t                      char_word,
  output logic                                res_valid,
  input  logic                                res_stall,
  output smd_pkg::result_t                    res
);
  import smd_pkg::*;

  char_t      in_q;
  logic       in_vld;
  logic       advance;
  logic       room2;
  logic       two;
  logic [1:0] push_n;
  result_t    res0, res1;
  cfg_wr_t    cfg;

  assign cfg.en    = wr_en;
  assign cfg.index = wr_index;
  assign cfg.data  = wr_data;

  // hold the input word until the queue can take both possible results
  assign advance    = in_vld && room2;
  assign char_stall = in_vld && !room2;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (char_valid && !char_stall) begin
      in_vld <= 1'b1;
    end else if (advance) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (char_valid && !char_stall) begin
      in_q <= char_word;
    end
  end

  assign push_n = advance ? (two ? 2'd2 : 2'd1) : 2'd0;

  smd_core #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .fire (advance),
    .item (in_q),
    .res0 (res0),
    .res1 (res1),
    .two  (two)
  );

  smd_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_n    (push_n),
    .wdata0    (res0),
    .wdata1    (res1),
    .room2     (room2),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule
